/* design/pixel_contrast_brightness_adjust_unit_assert.svh */
// assertion macros for the pixel adjust block
`ifndef PIXEL_CONTRAST_BRIGHTNESS_ADJUST_UNIT_ASSERT_SVH
`define PIXEL_CONTRAST_BRIGHTNESS_ADJUST_UNIT_ASSERT_SVH

// consequent checked in the same cycle
`define PCBA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define PCBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/pcba_pkg.sv */
`default_nettype none

package pcba_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_CONTRAST   = 2'd0;
  localparam cfg_idx_t CFG_BRIGHTNESS = 2'd1;

  typedef logic [7:0] pix_t;

  // contrast gain, q8.16
  typedef logic signed [24:0] gain_t;
  // brightness offset on luma, q.16
  typedef logic signed [17:0] boost_t;

  localparam gain_t GAIN_RESET = 25'sd65536;

  typedef struct packed {
    logic   busy;
    gain_t  gain;
    boost_t boost;
  } adj_t;

  // matrix coefficients, q2.14
  typedef logic signed [16:0] coef_t;

  localparam coef_t FWD_COEF [9] = '{
    17'sd3483,  17'sd11718, 17'sd1183,
    -17'sd1637, -17'sd5505, 17'sd7143,
    17'sd10076, -17'sd9152, -17'sd922
  };

  localparam coef_t INV_RV = 17'sd20976;
  localparam coef_t INV_GU = -17'sd3519;
  localparam coef_t INV_GV = -17'sd6234;
  localparam coef_t INV_BU = 17'sd34864;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef logic [16:0] norm_tab_t [256];
  typedef boost_t boost_tab_t [256];

  // byte to q.16, rounded
  function automatic norm_tab_t build_norm_tab();
    norm_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = 17'((i * 65536 + 127) / 255);
    end
    return tab;
  endfunction

  // signed percent to q.16 offset, rounded half away from zero
  function automatic boost_tab_t build_boost_tab();
    boost_tab_t tab;
    int b;
    int q;
    for (int i = 0; i < 256; i++) begin
      b = (i < 128) ? i : i - 256;
      q = (((b < 0) ? -b : b) * 65536 + 50) / 100;
      tab[i] = (b < 0) ? 18'(-q) : 18'(q);
    end
    return tab;
  endfunction

  localparam norm_tab_t  NORM_TAB  = build_norm_tab();
  localparam boost_tab_t BOOST_TAB = build_boost_tab();

endpackage

`default_nettype wire

/* design/pcba_if.sv */
`default_nettype none

interface pcba_in_if;
  logic          valid;
  logic          ready;
  pcba_pkg::pix_t red_in;
  pcba_pkg::pix_t green_in;
  pcba_pkg::pix_t blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface pcba_out_if;
  logic          valid;
  logic          ready;
  pcba_pkg::pix_t red_out;
  pcba_pkg::pix_t green_out;
  pcba_pkg::pix_t blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

`default_nettype wire

/* design/pcba_cfg.sv */
`default_nettype none

module pcba_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  pcba_pkg::cfg_idx_t              cfg_idx,
  input  logic [pcba_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output pcba_pkg::adj_t                  adj
);
  import pcba_pkg::*;

  localparam int          DVD_W    = 34;
  localparam int          DEN_W    = 18;
  localparam int          GAIN_W   = 24;
  localparam int          CNT_W    = 6;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W - 1);

  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;
  logic             busy_r, busy_nxt;
  gain_t            gain_r, gain_nxt;
  boost_t           boost_r, boost_nxt;

  logic signed [8:0]  c_w;
  logic signed [9:0]  cs_w;
  logic signed [10:0] cd_w;
  logic [DEN_W-1:0]   num_hi_w;
  logic [DEN_W-1:0]   den_w;
  logic [DVD_W-1:0]   dvd_load_w;
  logic [DEN_W:0]     rem_sh_w;
  logic               q_bit_w;
  logic [DVD_W-1:0]   quo_w;
  logic [GAIN_W:0]    mag_w;

  // divisor 255*(259-c), dividend 259*|c+255|*2^16 plus half divisor
  always_comb begin
    c_w        = $signed(cfg_wdata);
    cs_w       = 10'(c_w) + 10'sd255;
    cd_w       = 11'sd259 - 11'(c_w);
    den_w      = {8'd0, cd_w[9:0]} * 18'd255;
    num_hi_w   = cs_w[9] ? 18'd259 : {9'd0, cs_w[8:0]} * 18'd259;
    dvd_load_w = {num_hi_w, 16'd0} + DVD_W'(den_w >> 1);
  end

  // one quotient bit per cycle
  always_comb begin
    rem_sh_w = {rem_r, dvd_r[DVD_W-1]};
    q_bit_w  = rem_sh_w >= {1'b0, den_r};
    quo_w    = {dvd_r[DVD_W-2:0], q_bit_w};
    mag_w    = {1'b0, quo_w[GAIN_W-1:0]};
  end

  always_comb begin
    dvd_nxt   = dvd_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    busy_nxt  = busy_r;
    gain_nxt  = gain_r;
    boost_nxt = boost_r;

    if (busy_r) begin
      dvd_nxt = quo_w;
      rem_nxt = q_bit_w ? DEN_W'(rem_sh_w - {1'b0, den_r}) : rem_sh_w[DEN_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_LAST) begin
        busy_nxt = 1'b0;
        gain_nxt = neg_r ? -$signed(mag_w) : $signed(mag_w);
      end
    end

    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_CONTRAST: begin
          dvd_nxt  = dvd_load_w;
          den_nxt  = den_w;
          rem_nxt  = '0;
          cnt_nxt  = '0;
          neg_nxt  = cs_w[9];
          busy_nxt = 1'b1;
        end
        CFG_BRIGHTNESS: begin
          boost_nxt = BOOST_TAB[cfg_wdata[7:0]];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cnt_r   <= '0;
      gain_r  <= GAIN_RESET;
      boost_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      cnt_r   <= cnt_nxt;
      gain_r  <= gain_nxt;
      boost_r <= boost_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign adj = '{busy: busy_r, gain: gain_r, boost: boost_r};

endmodule

`default_nettype wire

/* design/pcba_pipe.sv */
`default_nettype none

module pcba_pipe (
  input  logic              clk,
  input  logic              rst_n,
  pcba_in_if.sink           in_pix,
  pcba_out_if.source        out_pix,
  input  pcba_pkg::adj_t    adj
);
  import pcba_pkg::*;

  localparam int NST = 9;

  function automatic pix_t to_byte(input logic signed [25:0] v);
    logic [23:0] sc;
    pix_t        res;
    sc = {v[15:0], 8'd0} - {8'd0, v[15:0]};
    if (v[25]) begin
      res = 8'd0;
    end else if (v[24:16] != 9'd0) begin
      res = 8'hff;
    end else begin
      res = sc[23:16];
    end
    return res;
  endfunction

  logic [NST-1:0] vld_r;
  logic           adv;

  pix_t pin [3];

  logic signed [17:0] s1_d_r   [3], s1_d_nxt   [3];
  logic signed [42:0] s2_p_r   [3], s2_p_nxt   [3];
  logic signed [24:0] s3_c_r   [3], s3_c_nxt   [3];
  logic signed [41:0] s4_f_r   [9], s4_f_nxt   [9];
  logic signed [25:0] s5_yuv_r [3], s5_yuv_nxt [3];
  logic        [16:0] s6_y_r, s6_y_nxt;
  logic signed [25:0] s6_u_r, s6_u_nxt;
  logic signed [25:0] s6_v_r, s6_v_nxt;
  logic        [30:0] s7_y_r, s7_y_nxt;
  logic signed [42:0] s7_rv_r, s7_rv_nxt;
  logic signed [42:0] s7_gu_r, s7_gu_nxt;
  logic signed [42:0] s7_gv_r, s7_gv_nxt;
  logic signed [42:0] s7_bu_r, s7_bu_nxt;
  logic signed [25:0] s8_o_r   [3], s8_o_nxt   [3];
  pix_t               s9_o_r   [3], s9_o_nxt   [3];

  logic signed [43:0] fsum      [3];
  logic signed [26:0] y_boost;
  logic signed [31:0] y_sh;
  logic signed [43:0] isum      [3];

  assign adv          = !vld_r[NST-1] || out_pix.ready;
  assign in_pix.ready = adv && !adj.busy;

  always_comb begin
    pin[0] = in_pix.red_in;
    pin[1] = in_pix.green_in;
    pin[2] = in_pix.blue_in;
  end

  // normalise, contrast gain about mid grey
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_d_nxt[i] = $signed({1'b0, NORM_TAB[pin[i]]}) - 18'sd32768;
      s2_p_nxt[i] = adj.gain * s1_d_r[i];
      s3_c_nxt[i] = 25'((s2_p_r[i] + 43'sd32768) >>> 16) + 25'sd32768;
    end
  end

  // forward matrix
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        s4_f_nxt[3*r+k] = FWD_COEF[3*r+k] * s3_c_r[k];
      end
      fsum[r] = 44'(s4_f_r[3*r]) + 44'(s4_f_r[3*r+1]) + 44'(s4_f_r[3*r+2]) + 44'sd8192;
      s5_yuv_nxt[r] = 26'(fsum[r] >>> 14);
    end
  end

  // luma offset and clamp
  always_comb begin
    y_boost = 27'(s5_yuv_r[0]) + 27'(adj.boost);
    if (y_boost < 27'sd0) begin
      s6_y_nxt = '0;
    end else if (y_boost > 27'sd65536) begin
      s6_y_nxt = ONE_Q16;
    end else begin
      s6_y_nxt = y_boost[16:0];
    end
    s6_u_nxt = s5_yuv_r[1];
    s6_v_nxt = s5_yuv_r[2];
  end

  // inverse matrix and byte conversion
  always_comb begin
    s7_y_nxt  = {s6_y_r, 14'd0};
    s7_rv_nxt = INV_RV * s6_v_r;
    s7_gu_nxt = INV_GU * s6_u_r;
    s7_gv_nxt = INV_GV * s6_v_r;
    s7_bu_nxt = INV_BU * s6_u_r;

    y_sh    = $signed({1'b0, s7_y_r});
    isum[0] = 44'(y_sh) + 44'(s7_rv_r) + 44'sd8192;
    isum[1] = 44'(y_sh) + 44'(s7_gu_r) + 44'(s7_gv_r) + 44'sd8192;
    isum[2] = 44'(y_sh) + 44'(s7_bu_r) + 44'sd8192;
    for (int i = 0; i < 3; i++) begin
      s8_o_nxt[i] = 26'(isum[i] >>> 14);
      s9_o_nxt[i] = to_byte(s8_o_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_pix.valid && !adj.busy};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_d_r   <= s1_d_nxt;
      s2_p_r   <= s2_p_nxt;
      s3_c_r   <= s3_c_nxt;
      s4_f_r   <= s4_f_nxt;
      s5_yuv_r <= s5_yuv_nxt;
      s6_y_r   <= s6_y_nxt;
      s6_u_r   <= s6_u_nxt;
      s6_v_r   <= s6_v_nxt;
      s7_y_r   <= s7_y_nxt;
      s7_rv_r  <= s7_rv_nxt;
      s7_gu_r  <= s7_gu_nxt;
      s7_gv_r  <= s7_gv_nxt;
      s7_bu_r  <= s7_bu_nxt;
      s8_o_r   <= s8_o_nxt;
      s9_o_r   <= s9_o_nxt;
    end
  end

  assign out_pix.valid     = vld_r[NST-1];
  assign out_pix.red_out   = s9_o_r[0];
  assign out_pix.green_out = s9_o_r[1];
  assign out_pix.blue_out  = s9_o_r[2];

endmodule

`default_nettype wire

/* design/pixel_contrast_brightness_adjust_unit.sv */
// RGB888 contrast and brightness adjust. One pixel word is accepted per clock while
// the output is not stalled and no gain division runs, and the adjusted word is driven
// from an output register; a stall on the output freezes the whole nine-stage
// pipeline without losing or repeating a word. Writing the contrast register starts a
// bit-serial divider for the gain, during which in_pix.ready is held low; brightness
// takes effect on the cycle after its write. Register indexes above one are ignored.
`default_nettype none

module pixel_contrast_brightness_adjust_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  pcba_in_if.sink                         in_pix,
  pcba_out_if.source                      out_pix,
  input  logic                            cfg_we,
  input  pcba_pkg::cfg_idx_t              cfg_idx,
  input  logic [pcba_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pcba_pkg::*;

  adj_t adj;

  pcba_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .adj       (adj)
  );

  pcba_pipe u_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .out_pix (out_pix),
    .adj     (adj)
  );

endmodule

`default_nettype wire

/* design/pcba_checker.sv */
`default_nettype none

`include "pixel_contrast_brightness_adjust_unit_assert.svh"

module pcba_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input pcba_pkg::pix_t       red_out,
  input pcba_pkg::pix_t       green_out,
  input pcba_pkg::pix_t       blue_out,
  input logic                 cfg_we,
  input pcba_pkg::cfg_idx_t   cfg_idx
);
  import pcba_pkg::*;

  `PCBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid,
    "result word dropped while stalled")

  `PCBA_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
    $stable(red_out) && $stable(green_out) && $stable(blue_out),
    "result word changed while stalled")

  `PCBA_ASSERT_NEXT(a_gain_block, cfg_we && cfg_idx == CFG_CONTRAST, !in_ready,
    "input taken right after contrast write")

  `PCBA_ASSERT_SAME(a_gain_busy, cfg_we && cfg_idx == CFG_CONTRAST, ##20 !in_ready,
    "input taken while gain still being divided")

endmodule

bind pixel_contrast_brightness_adjust_unit pcba_checker u_pcba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_pix.ready),
  .out_valid (out_pix.valid),
  .out_ready (out_pix.ready),
  .red_out   (out_pix.red_out),
  .green_out (out_pix.green_out),
  .blue_out  (out_pix.blue_out),
  .cfg_we    (cfg_we),
  .cfg_idx   (cfg_idx)
);

`default_nettype wire

/* tb/pixel_contrast_brightness_adjust_unit_tb.sv */
`default_nettype none

module pixel_contrast_brightness_adjust_unit_tb;
  import pcba_pkg::*;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
  } rgb_word_t;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned DRAIN_CYCLES   = 24;
  localparam int          PHASE_WORDS    = 75;

  localparam cfg_idx_t CFG_SPARE_LO = 2'd2;
  localparam cfg_idx_t CFG_SPARE_HI = 2'd3;

  localparam longint RGB2YUV [9] = '{
    3483, 11718, 1183,
    -1637, -5505, 7143,
    10076, -9152, -922
  };
  localparam longint YUV2RGB [9] = '{
    16384, 0, 20976,
    16384, -3519, -6234,
    16384, 34864, 0
  };

  localparam logic [23:0] CORNER_PIX [12] = '{
    24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00,
    24'h0000ff, 24'h808080, 24'h7f7f7f, 24'h00ffff,
    24'hffff00, 24'h0102fe, 24'haa5533, 24'hfe01ff
  };

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_idx = CFG_CONTRAST;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  pcba_in_if  in_if ();
  pcba_out_if out_if ();

  pixel_contrast_brightness_adjust_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_if),
    .out_pix   (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  longint contrast_set = 0;
  longint brightness_set = 0;
  longint gain_q16 = 65536;
  longint boost_q16 = 0;

  rgb_word_t pix_queue [$];
  rgb_word_t expected_pix [$];

  bit          idle_on = 1'b0;
  int unsigned hold_reqs = 0;
  int unsigned hold_done = 0;
  int unsigned errors = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  int unsigned quiet_cycles = 0;
  rgb_word_t   drv_px;
  rgb_word_t   sent_px;
  rgb_word_t   got_px;
  rgb_word_t   want_px;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint round_shift(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint div_half_away(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic pix_t sat_byte(longint v);
    longint s;
    if (v < 0) return 8'h00;
    s = (v * 255) >>> 16;
    if (s > 255) return 8'hff;
    return pix_t'(s);
  endfunction

  function automatic rgb_word_t adjust_pixel(rgb_word_t px);
    longint    lin [3];
    longint    yuv [3];
    longint    x;
    pix_t      chan [3];
    rgb_word_t res;
    chan[0] = px.red;
    chan[1] = px.green;
    chan[2] = px.blue;
    for (int i = 0; i < 3; i++) begin
      x = div_half_away(longint'(chan[i]) * 65536, 255);
      lin[i] = round_shift(gain_q16 * (x - 32768), 16) + 32768;
    end
    for (int i = 0; i < 3; i++) begin
      yuv[i] = round_shift(RGB2YUV[3*i] * lin[0] + RGB2YUV[3*i+1] * lin[1] +
                           RGB2YUV[3*i+2] * lin[2], 14);
    end
    yuv[0] += boost_q16;
    if (yuv[0] < 0) yuv[0] = 0;
    if (yuv[0] > 65536) yuv[0] = 65536;
    for (int i = 0; i < 3; i++) begin
      lin[i] = round_shift(YUV2RGB[3*i] * yuv[0] + YUV2RGB[3*i+1] * yuv[1] +
                           YUV2RGB[3*i+2] * yuv[2], 14);
    end
    res.red   = sat_byte(lin[0]);
    res.green = sat_byte(lin[1]);
    res.blue  = sat_byte(lin[2]);
    return res;
  endfunction

  function automatic void apply_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_CONTRAST) begin
      contrast_set = longint'($signed(data));
      gain_q16 = div_half_away(259 * (contrast_set + 255) * 65536,
                               255 * (259 - contrast_set));
    end else if (idx == CFG_BRIGHTNESS) begin
      brightness_set = longint'($signed(data[7:0]));
      boost_q16 = div_half_away(brightness_set * 65536, 100);
    end
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic pix_t pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h7f;
      3: return 8'h80;
      default: return pix_t'($urandom);
    endcase
  endfunction

  function automatic rgb_word_t random_pixel();
    rgb_word_t px;
    px.red   = pick_byte();
    px.green = pick_byte();
    px.blue  = pick_byte();
    if ($urandom_range(0, 7) == 0) begin
      px.green = px.red;
      px.blue  = px.red;
    end
    return px;
  endfunction

  function automatic void check_field(string name, pix_t want, pix_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    apply_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_levels(int c, int b);
    write_reg(CFG_CONTRAST, 9'(c));
    write_reg(CFG_BRIGHTNESS, {1'($urandom), 8'(b)});
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pix_queue.size() != 0 || in_if.valid || expected_pix.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(int n_words, bit idling, bit long_hold);
    @(negedge clk);
    idle_on = idling;
    if (long_hold) hold_reqs++;
    for (int i = 0; i < n_words; i++) pix_queue.push_back(random_pixel());
    wait_idle();
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        sent_px.red   = in_if.red_in;
        sent_px.green = in_if.green_in;
        sent_px.blue  = in_if.blue_in;
        expected_pix.push_back(adjust_pixel(sent_px));
        in_gap = idle_on ? gap_len() : 0;
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_gap != 0) begin
          in_if.valid <= 1'b0;
          in_gap--;
        end else if (pix_queue.size() != 0) begin
          drv_px = pix_queue.pop_front();
          in_if.valid    <= 1'b1;
          in_if.red_in   <= drv_px.red;
          in_if.green_in <= drv_px.green;
          in_if.blue_in  <= drv_px.blue;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got_px.red   = out_if.red_out;
        got_px.green = out_if.green_out;
        got_px.blue  = out_if.blue_out;
        if (expected_pix.size() == 0) begin
          $display("%0t: word with nothing expected, expected none, actual %h", $time,
                   got_px);
          errors++;
        end else begin
          want_px = expected_pix.pop_front();
          check_field("red_out", want_px.red, got_px.red);
          check_field("green_out", want_px.green, got_px.green);
          check_field("blue_out", want_px.blue, got_px.blue);
        end
      end
      if (hold_done != hold_reqs) begin
        hold_done++;
        out_gap = LONG_HOLD;
      end
      if (out_gap != 0) begin
        out_if.ready <= 1'b0;
        out_gap--;
      end else begin
        out_if.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) out_gap = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("pixel_contrast_brightness_adjust_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // corner words at reset settings
    @(negedge clk);
    idle_on = 1'b0;
    foreach (CORNER_PIX[i]) pix_queue.push_back(rgb_word_t'(CORNER_PIX[i]));
    wait_idle();

    set_levels(255, 100);
    run_phase(PHASE_WORDS, 1'b1, 1'b0);
    set_levels(-255, -100);
    run_phase(PHASE_WORDS, 1'b1, 1'b1);
    // contrast below range, inverting gain
    set_levels(-256, 0);
    run_phase(PHASE_WORDS, 1'b0, 1'b0);
    set_levels(0, 127);
    run_phase(PHASE_WORDS, 1'b1, 1'b0);
    set_levels(0, -128);
    run_phase(PHASE_WORDS, 1'b1, 1'b0);

    // spare indexes must leave the settings alone
    write_reg(CFG_CONTRAST, 9'(64));
    write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
    run_phase(PHASE_WORDS, 1'b1, 1'b0);

    for (int k = 0; k < 6; k++) begin
      set_levels(int'($signed(9'($urandom))), int'($signed(8'($urandom))));
      run_phase(PHASE_WORDS, k != 2, k == 3);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("pixel_contrast_brightness_adjust_unit_tb: PASS");
    end else begin
      $display("pixel_contrast_brightness_adjust_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+design
design/pcba_pkg.sv
design/pcba_if.sv
design/pcba_cfg.sv
design/pcba_pipe.sv
design/pixel_contrast_brightness_adjust_unit.sv
design/pcba_checker.sv
tb/pixel_contrast_brightness_adjust_unit_tb.sv
